// ===== hdl/ebps_pkg.sv =====
// Shared types and constants for the exact byte pattern search unit.
package ebps_pkg;

    localparam int PATTERN_WORDS = 4;
    localparam int PATTERN_BYTES = 32;
    localparam int CFG_LEN_W     = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int COUNT_W       = 16;
    localparam int OUT_OFFSET_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES    = 3'd5;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic                    kind;
        logic [OUT_OFFSET_W-1:0] match_offset;
        logic [COUNT_W-1:0]      match_total;
        logic                    last;
    } t_out_item;

endpackage

// ===== hdl/exact_byte_pattern_search_unit.sv =====
// Exact byte pattern search over a streamed region.
//
// Bytes of a region enter on the input channel, one per transfer; region_end
// marks the final byte. Each byte is compared, together with the newest bytes
// held in a window, against the configured pattern. Every occurrence, until the
// match limit is reached, produces a match result carrying its start offset;
// the final byte also produces an end-of-region summary with the region length
// and match count, after which the region state clears. Registers are written
// through the configuration channel, which always accepts; the user must write
// them only while no byte is in flight, as the block does not enforce this.
// An accepted byte is held in the input register, evaluated there, and its
// results are written into a four-entry output queue that offers them in order.
// One byte is taken every cycle as long as the output side takes one result
// per cycle; a byte with two results needs two output transfers. When
// the receiver stalls, the queue fills and input ready drops once a byte waits
// in the input register and fewer than two queue entries are free.
// Reset clears the region state and loads pattern length one, an all-zero
// pattern and an unlimited match count.
module exact_byte_pattern_search_unit #(
    parameter int PATTERN_MAX = 32,
    parameter int OFFSET_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ebps_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ebps_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ebps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ebps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ebps_pkg::*;

    localparam int FILL_W     = $clog2(PATTERN_MAX + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FCNT_W     = 3;

    logic [CFG_LEN_W-1:0]  r_len;
    logic [CFG_DATA_W-1:0] r_pat_word [PATTERN_WORDS];
    logic [COUNT_W-1:0]    r_max;

    logic       r_in_valid;
    t_in_item   r_in;

    logic [7:0]             r_window [PATTERN_MAX];
    logic [FILL_W-1:0]      r_fill;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [COUNT_W-1:0]     r_found;
    logic                   r_limit;

    t_out_item          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [FCNT_W-1:0]  r_count;

    logic [7:0]             pat_byte [PATTERN_BYTES];
    logic [7:0]             win_next [PATTERN_MAX];
    logic [CFG_LEN_W-1:0]   len_c;
    logic [FILL_W-1:0]      n_fill;
    logic                   all_equal;
    logic                   hit;
    logic [COUNT_W-1:0]     found_inc;
    logic [COUNT_W-1:0]     n_found;
    logic                   n_limit;
    logic [OFFSET_BITS-1:0] start_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic                   advance;
    logic                   pop;
    logic [1:0]             push_cnt;
    t_out_item              match_res;
    t_out_item              summary_res;
    t_out_item              first_res;

    always_comb begin
        for (int b = 0; b < PATTERN_BYTES; b++) begin
            pat_byte[b] = r_pat_word[b / 8][(b % 8) * 8 +: 8];
        end
    end

    always_comb begin
        win_next[0] = r_in.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_next[k] = r_window[k-1];
        end
    end

    always_comb begin
        logic [CFG_LEN_W-1:0] idx;
        len_c = (r_len > CFG_LEN_W'(PATTERN_MAX)) ? CFG_LEN_W'(PATTERN_MAX) : r_len;
        n_fill = (r_fill < FILL_W'(PATTERN_MAX)) ? r_fill + FILL_W'(1) : r_fill;
        all_equal = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx = len_c - CFG_LEN_W'(j) - CFG_LEN_W'(1);
            if (CFG_LEN_W'(j) < len_c && win_next[j] != pat_byte[idx[4:0]]) begin
                all_equal = 1'b0;
            end
        end
    end

    assign hit = r_in_valid && (len_c != '0) && (CFG_LEN_W'(n_fill) >= len_c)
                 && !r_limit && all_equal;

    assign found_inc = (r_found != {COUNT_W{1'b1}}) ? r_found + COUNT_W'(1) : r_found;
    assign n_found   = hit ? found_inc : r_found;
    assign n_limit   = r_limit || (hit && r_max != '0 && found_inc >= r_max);
    assign start_pos = r_pos - OFFSET_BITS'(len_c - CFG_LEN_W'(1));
    assign n_pos     = r_pos + OFFSET_BITS'(1);

    always_comb begin
        match_res.kind         = KIND_MATCH;
        match_res.match_offset = OUT_OFFSET_W'(start_pos);
        match_res.match_total  = n_found;
        match_res.last         = !r_in.region_end;

        summary_res.kind         = KIND_SUMMARY;
        summary_res.match_offset = OUT_OFFSET_W'(n_pos);
        summary_res.match_total  = n_found;
        summary_res.last         = 1'b1;

        first_res = hit ? match_res : summary_res;
        push_cnt  = 2'(hit) + 2'(r_in.region_end);
    end

    assign advance     = r_in_valid && (r_count <= FCNT_W'(FIFO_DEPTH - 2));
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= CFG_LEN_W'(1);
            r_max  <= '0;
            for (int w = 0; w < PATTERN_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_PATTERN_WORD_0: r_pat_word[0] <= i_cfg_data;
                CFG_PATTERN_WORD_1: r_pat_word[1] <= i_cfg_data;
                CFG_PATTERN_WORD_2: r_pat_word[2] <= i_cfg_data;
                CFG_PATTERN_WORD_3: r_pat_word[3] <= i_cfg_data;
                CFG_MAX_MATCHES:    r_max <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_window[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_found <= '0;
            r_limit <= 1'b0;
        end else if (advance) begin
            if (r_in.region_end) begin
                r_fill  <= '0;
                r_pos   <= '0;
                r_found <= '0;
                r_limit <= 1'b0;
            end else begin
                r_fill  <= n_fill;
                r_pos   <= n_pos;
                r_found <= n_found;
                r_limit <= n_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_res;
        end
        if (advance && push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= summary_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (advance) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (advance ? FCNT_W'(push_cnt) : FCNT_W'(0))
                       - FCNT_W'(pop);
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCNT_W'(FIFO_DEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.region_end |=> r_fill == '0 && r_found == '0 && !r_limit)
        else $error("Region state did not clear after the final byte.");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_SUMMARY |-> o_out_data.last)
        else $error("A summary result is not marked as the last of its byte.");

endmodule

// ===== verif/exact_byte_pattern_search_unit_tb.sv =====
// Self-checking testbench for the exact byte pattern search unit.
module exact_byte_pattern_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebps_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int IDLE_PERCENT  = 18;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 150;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in_item              in_data    = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    t_in_item  bytes_to_send [$];
    t_out_item awaited [$];
    int        mismatches     = 0;
    logic      calm           = 1'b0;
    int        stall_requests = 0;
    int        stall_served   = 0;
    int        hold_left      = 0;
    int        quiet          = 0;

    logic [7:0]           window [PATTERN_BYTES];
    logic [31:0]          position;
    int unsigned          fill;
    logic [COUNT_W-1:0]   found;
    logic                 limit_hit;
    logic [CFG_LEN_W-1:0] pat_len;
    logic [63:0]          pat_word [PATTERN_WORDS];
    logic [COUNT_W-1:0]   match_cap;

    exact_byte_pattern_search_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void clear_region();
        for (int k = 0; k < PATTERN_BYTES; k++) window[k] = 8'h00;
        position  = '0;
        fill      = 0;
        found     = '0;
        limit_hit = 1'b0;
    endfunction

    task automatic scan_byte(input t_in_item item);
        int unsigned span;
        logic [31:0] here;
        logic        hit;
        t_out_item   res;
        span = (pat_len > PATTERN_BYTES) ? PATTERN_BYTES : pat_len;
        here = position;
        for (int k = PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = item.text_byte;
        if (fill < PATTERN_BYTES) fill++;
        if (span != 0 && fill >= span && !limit_hit) begin
            hit = 1'b1;
            for (int k = 0; k < span; k++) begin
                if (window[span-1-k] != pat_word[k/8][(k%8)*8 +: 8]) hit = 1'b0;
            end
            if (hit) begin
                if (found != 16'hFFFF) found++;
                if (match_cap != 0 && found >= match_cap) limit_hit = 1'b1;
                res.kind         = KIND_MATCH;
                res.match_offset = here - 32'(span - 1);
                res.match_total  = found;
                res.last         = !item.region_end;
                awaited.push_back(res);
            end
        end
        position = here + 1;
        if (item.region_end) begin
            res.kind         = KIND_SUMMARY;
            res.match_offset = position;
            res.match_total  = found;
            res.last         = 1'b1;
            awaited.push_back(res);
            clear_region();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 200)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin : drive_bytes
        t_in_item next_item;
        logic     next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            next_item  = in_data;
            if (in_valid && in_ready) begin
                scan_byte(in_data);
                next_valid = 1'b0;
            end
            if (!next_valid && bytes_to_send.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_item  = bytes_to_send.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
            in_data  <= next_item;
        end
    end

    always @(posedge clk) begin : take_results
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited.size() == 0) begin
                    flag_mismatch("result with nothing expected, offset",
                                  out_data.match_offset, '0);
                end else begin
                    want = awaited.pop_front();
                    if (out_data.kind != want.kind)
                        flag_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
                    if (out_data.match_offset != want.match_offset)
                        flag_mismatch("match_offset", out_data.match_offset,
                                      want.match_offset);
                    if (out_data.match_total != want.match_total)
                        flag_mismatch("match_total", 32'(out_data.match_total),
                                      32'(want.match_total));
                    if (out_data.last != want.last)
                        flag_mismatch("last", 32'(out_data.last), 32'(want.last));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (stall_served != stall_requests) begin
                stall_served <= stall_served + 1;
                hold_left    <= HOLD_CYCLES;
                out_ready    <= 1'b0;
            end else begin
                out_ready <= calm || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic void enqueue_byte(input logic [7:0] value, input logic region_end);
        t_in_item item;
        item.text_byte  = value;
        item.region_end = region_end;
        bytes_to_send.push_back(item);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PATTERN_LENGTH: pat_len     = value[CFG_LEN_W-1:0];
            CFG_PATTERN_WORD_0: pat_word[0] = value;
            CFG_PATTERN_WORD_1: pat_word[1] = value;
            CFG_PATTERN_WORD_2: pat_word[2] = value;
            CFG_PATTERN_WORD_3: pat_word[3] = value;
            CFG_MAX_MATCHES:    match_cap   = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_LEN_W-1:0] len, input logic [63:0] w0,
                                 input logic [63:0] w1, input logic [63:0] w2,
                                 input logic [63:0] w3, input logic [COUNT_W-1:0] cap);
        @(posedge clk);
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        write_reg(CFG_PATTERN_WORD_0, w0);
        write_reg(CFG_PATTERN_WORD_1, w1);
        write_reg(CFG_PATTERN_WORD_2, w2);
        write_reg(CFG_PATTERN_WORD_3, w3);
        write_reg(CFG_MAX_MATCHES, 64'(cap));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (bytes_to_send.size() != 0 || in_valid || awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int items);
        logic [7:0]           pat [PATTERN_BYTES];
        logic [7:0]           alpha [2];
        logic [63:0]          w [PATTERN_WORDS];
        logic [CFG_LEN_W-1:0] len;
        logic [COUNT_W-1:0]   cap;
        logic [7:0]           value;
        logic                 narrow;
        int                   span;
        int                   region_left;
        int                   plant_pos;
        narrow   = $urandom_range(2) == 0;
        alpha[0] = 8'($urandom);
        alpha[1] = 8'($urandom);
        case ($urandom_range(7))
            0:       len = 6'd1;
            1:       len = 6'd2;
            2:       len = 6'd32;
            3:       len = 6'($urandom_range(33, 63));
            4:       len = 6'd0;
            default: len = 6'($urandom_range(1, 12));
        endcase
        case ($urandom_range(5))
            0, 1:    cap = '0;
            2:       cap = 16'd1;
            3:       cap = 16'hFFFF;
            default: cap = 16'($urandom_range(1, 6));
        endcase
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            pat[k] = narrow ? alpha[$urandom_range(1)] : 8'($urandom);
            w[k/8][(k%8)*8 +: 8] = pat[k];
        end
        load_settings(len, w[0], w[1], w[2], w[3], cap);
        span = (len > PATTERN_BYTES) ? PATTERN_BYTES : ((len == 0) ? 1 : len);
        region_left = 0;
        plant_pos   = -1;
        for (int n = 0; n < items; n++) begin
            if (region_left == 0)
                region_left = ($urandom_range(15) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 40);
            if (plant_pos < 0 && $urandom_range(5) == 0) plant_pos = 0;
            if (plant_pos >= 0) begin
                value = pat[plant_pos];
                plant_pos++;
                if (plant_pos == span) plant_pos = -1;
            end else begin
                value = narrow ? alpha[$urandom_range(1)] : 8'($urandom);
            end
            enqueue_byte(value, region_left == 1);
            region_left--;
        end
    endtask

    initial begin
        pat_len   = 6'd1;
        match_cap = '0;
        for (int k = 0; k < PATTERN_WORDS; k++) pat_word[k] = '0;
        clear_region();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Settings from reset: a one-byte all-zero pattern with no limit.
        enqueue_byte(8'h00, 1'b0);
        enqueue_byte(8'hFF, 1'b0);
        enqueue_byte(8'h00, 1'b1);
        wait_idle();

        // Overlapping occurrences, then a region shorter than the pattern.
        load_settings(6'd4, 64'h0000_0000_3412_3412, '0, '0, '0, '0);
        for (int k = 0; k < 6; k++) enqueue_byte((k % 2 == 0) ? 8'h12 : 8'h34, k == 5);
        enqueue_byte(8'h12, 1'b0);
        enqueue_byte(8'h34, 1'b1);
        wait_idle();

        load_settings(6'd0, '1, '1, '1, '1, '0);
        enqueue_byte(8'hFF, 1'b0);
        enqueue_byte(8'h00, 1'b1);
        wait_idle();

        load_settings(6'd63, '1, '1, '1, '1, '0);
        for (int k = 0; k < 3; k++) enqueue_byte(8'hFF, k == 2);
        wait_idle();

        // A limit of one, then a region left open across a settings change.
        load_settings(6'd1, 64'hAA, '0, '0, '0, 16'd1);
        for (int k = 0; k < 3; k++) enqueue_byte(8'hAA, k == 2);
        enqueue_byte(8'hAA, 1'b0);
        enqueue_byte(8'hAA, 1'b0);
        wait_idle();
        load_settings(6'd2, 64'hAAAA, '0, '0, '0, '0);
        enqueue_byte(8'hAA, 1'b1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 6) calm <= 1'b1;
            random_phase(PHASE_ITEMS);
            if (ph == 3) stall_requests <= stall_requests + 1;
            wait_idle();
            if (ph == 6) calm <= 1'b0;
        end
        enqueue_byte(8'($urandom), 1'b1);
        wait_idle();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
